/* rtl/decaying_sketch_rate_limiter_unit_assert.svh */
// assertion macros for the rate limiter rtl
`ifndef DECAYING_SKETCH_RATE_LIMITER_UNIT_ASSERT_SVH
`define DECAYING_SKETCH_RATE_LIMITER_UNIT_ASSERT_SVH
`ifndef SYNTH
// check a property on every clock edge outside reset
`define DSRL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dsrl assertion failed");
// check a property on every clock edge, reset included
`define DSRL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dsrl assertion failed");
`else
`define DSRL_ASSERT(lbl, clk, rstn, prop)
`define DSRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/dsrl_pkg.sv */
// ----------------------------------------------------------------------------
// dsrl_pkg
// types and constants of the decaying sketch rate limiter
// ----------------------------------------------------------------------------
`default_nettype none
package dsrl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned PROBE_COUNT_DEF = 3;
  localparam int unsigned DECAY_SHIFT_DEF = 8;

  // widest slot index carried in the queue (table up to 2^20 entries)
  localparam int unsigned SLOT_W_MAX  = 20;
  localparam int unsigned COST_W      = 12;
  localparam int unsigned STAMP_W     = 16;
  localparam int unsigned HEAT_W      = 16;
  localparam int unsigned MIN_W       = 17;
  localparam int unsigned TRIES_W     = 7;
  localparam logic [TRIES_W-1:0] MAX_TRIES = 7'd64;
  localparam logic [3:0]  DECAY_LIMIT = 4'd15;
  localparam logic [HEAT_W-1:0] HEAT_MAX = 16'hffff;
  localparam logic [MIN_W-1:0]  MIN_TOP  = 17'd67583;
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes on the configuration port
  localparam logic [1:0] REG_FILTER_ENABLE  = 2'd0;
  localparam logic [1:0] REG_HASH_SEED      = 2'd1;
  localparam logic [1:0] REG_HEAT_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] packet_bytes;
    logic [31:0] current_seconds;
  } in_t;

  typedef struct packed {
    logic        allow;
    logic [16:0] min_heat;
  } out_t;

  // one probe handed from the hash front to the table back
  typedef struct packed {
    logic                  bypass;
    logic                  last;
    logic [SLOT_W_MAX-1:0] slot;
    logic [COST_W-1:0]     cost;
    logic [STAMP_W-1:0]    stamp;
  } probe_t;

endpackage
`default_nettype wire

/* rtl/dsrl_front.sv */
// ----------------------------------------------------------------------------
// dsrl_front
// hash chain front: per packet a bypass probe if disabled, else distinct table probes
// ----------------------------------------------------------------------------
`default_nettype none
module dsrl_front #(
  parameter int unsigned TABLE_DEPTH = dsrl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned PROBE_COUNT = dsrl_pkg::PROBE_COUNT_DEF,
  parameter int unsigned DECAY_SHIFT = dsrl_pkg::DECAY_SHIFT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire dsrl_pkg::in_t   in_data_i,
  input  wire logic            enable_i,
  input  wire logic [31:0]     seed_i,
  output logic                 push_o,
  input  wire logic            full_i,
  output dsrl_pkg::probe_t     probe_o
);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned PW = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL  = 6'b000010,
    F_MIX  = 6'b000100,
    F_FALL = 6'b001000,
    F_PUSH = 6'b010000,
    F_BYP  = 6'b100000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [31:0] addr_q, hash_q, prod_q;
  logic [dsrl_pkg::COST_W-1:0]  cost_q;
  logic [dsrl_pkg::STAMP_W-1:0] stamp_q;
  logic [dsrl_pkg::TRIES_W-1:0] tries_q;
  logic [PW-1:0] probe_q;
  logic [3:0] cand_q;
  logic [IDX_W-1:0] slot_q;
  logic [IDX_W-1:0] used_q [PROBE_COUNT];
  logic [31:0] h1, h2;
  logic [IDX_W-1:0] hslot, cslot;
  logic hit_h, hit_c, last;

  // mix step of the hash chain
  always_comb begin
    h1 = prod_q ^ (prod_q >> 16);
    h2 = h1 + (h1 >> 7);
    hslot = h2[IDX_W-1:0] ^ IDX_W'({25'd0, tries_q});
    cslot = IDX_W'(cand_q);
  end

  // compare candidates against slots already taken by this packet
  always_comb begin
    hit_h = 1'b0;
    hit_c = 1'b0;
    for (int k = 0; k < PROBE_COUNT; k++) begin
      if (PW'(k) < probe_q && used_q[k] == hslot) hit_h = 1'b1;
      if (PW'(k) < probe_q && used_q[k] == cslot) hit_c = 1'b1;
    end
  end

  assign last = (probe_q == PW'(PROBE_COUNT - 1));
  assign in_ready_o = (state_q == F_IDLE);
  assign push_o = ((state_q == F_PUSH) || (state_q == F_BYP)) && !full_i;

  always_comb begin
    probe_o.bypass = (state_q == F_BYP);
    probe_o.last   = last;
    probe_o.slot   = dsrl_pkg::SLOT_W_MAX'(slot_q);
    probe_o.cost   = cost_q;
    probe_o.stamp  = stamp_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_valid_i) state_d = enable_i ? F_MUL : F_BYP;
      F_MUL:  state_d = F_MIX;
      F_MIX: begin
        if (!hit_h) state_d = F_PUSH;
        else if (tries_q == dsrl_pkg::MAX_TRIES) state_d = F_FALL;
        else state_d = F_MUL;
      end
      F_FALL: if (!hit_c) state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = last ? F_IDLE : F_MUL;
      F_BYP:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        addr_q  <= in_data_i.source_address;
        cost_q  <= dsrl_pkg::COST_W'({1'b0, in_data_i.packet_bytes[15:5]} + 12'd1);
        stamp_q <= dsrl_pkg::STAMP_W'(in_data_i.current_seconds >> DECAY_SHIFT);
        hash_q  <= seed_i;
        tries_q <= 7'd1;
        probe_q <= '0;
      end
      F_MUL: prod_q <= 32'(hash_q * addr_q);
      F_MIX: begin
        hash_q <= h2;
        slot_q <= hslot;
        cand_q <= '0;
        tries_q <= tries_q + 7'd1;
      end
      F_FALL: begin
        slot_q <= cslot;
        cand_q <= cand_q + 4'd1;
      end
      F_PUSH: if (!full_i) begin
        for (int k = 0; k < PROBE_COUNT; k++) begin
          if (PW'(k) == probe_q) used_q[k] <= slot_q;
        end
        probe_q <= probe_q + PW'(1);
        tries_q <= 7'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/dsrl_queue.sv */
// ----------------------------------------------------------------------------
// dsrl_queue
// short probe queue between hash front and table back
// ----------------------------------------------------------------------------
`default_nettype none
module dsrl_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dsrl_pkg::probe_t wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output dsrl_pkg::probe_t      rdata_o
);
  localparam int unsigned AW = $clog2(dsrl_pkg::QUEUE_DEPTH);

  dsrl_pkg::probe_t mem_q [dsrl_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0] cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(dsrl_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

/* rtl/dsrl_back.sv */
// ----------------------------------------------------------------------------
// dsrl_back
// table back: clear after reset, read-modify-write of heat slots and result forming
// ----------------------------------------------------------------------------
`default_nettype none
`include "decaying_sketch_rate_limiter_unit_assert.svh"
module dsrl_back #(
  parameter int unsigned TABLE_DEPTH = dsrl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire dsrl_pkg::probe_t probe_i,
  output logic                  pop_o,
  input  wire logic [31:0]      threshold_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dsrl_pkg::out_t        out_data_o
);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_READ  = 5'b00100,
    B_CALC  = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rdata_q;
  logic [IDX_W-1:0] clr_q;
  dsrl_pkg::probe_t cur_q;
  logic [dsrl_pkg::MIN_W-1:0] min_q, min_d, newh;
  logic [15:0] elapsed, decayed, sat;
  logic out_valid_q, out_free, we;
  dsrl_pkg::out_t out_q;
  logic [IDX_W-1:0] waddr;
  logic [31:0] wdata;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign pop_o = (state_q == B_IDLE) && valid_i && (!probe_i.bypass || out_free);

  // decay, charge and saturate one slot
  always_comb begin
    elapsed = cur_q.stamp - rdata_q[15:0];
    decayed = (elapsed > 16'(dsrl_pkg::DECAY_LIMIT)) ? 16'd0
            : (rdata_q[31:16] >> elapsed[3:0]);
    newh = {1'b0, decayed} + dsrl_pkg::MIN_W'(cur_q.cost);
    sat = newh[16] ? dsrl_pkg::HEAT_MAX : newh[15:0];
    min_d = (newh < min_q) ? newh : min_q;
  end

  // table write port
  always_comb begin
    we = (state_q == B_CLEAR) || (state_q == B_CALC);
    waddr = (state_q == B_CLEAR) ? clr_q : cur_q.slot[IDX_W-1:0];
    wdata = (state_q == B_CLEAR) ? 32'd0 : {sat, cur_q.stamp};
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[cur_q.slot[IDX_W-1:0]];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: if (clr_q == IDX_W'(TABLE_DEPTH - 1)) state_d = B_IDLE;
      B_IDLE:  if (pop_o && !probe_i.bypass) state_d = B_READ;
      B_READ:  state_d = B_CALC;
      B_CALC:  state_d = cur_q.last ? B_OUT : B_IDLE;
      B_OUT:   if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      min_q       <= '1;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + IDX_W'(1);
      if (state_q == B_CALC) min_q <= min_d;
      if (state_q == B_OUT && out_free) min_q <= '1;
      if ((state_q == B_OUT && out_free) || (pop_o && probe_i.bypass)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // probe and result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= probe_i;
    if (pop_o && probe_i.bypass) begin
      out_q.allow    <= 1'b1;
      out_q.min_heat <= '0;
    end else if (state_q == B_OUT && out_free) begin
      out_q.allow    <= ({15'd0, min_q} < threshold_i);
      out_q.min_heat <= min_q;
    end
  end

  // checks
  `DSRL_ASSERT(a_no_pop_clear, clk_i, rst_ni, (state_q == B_CLEAR) |-> !pop_o)
  `DSRL_ASSERT(a_we_state, clk_i, rst_ni, we |-> (state_q == B_CLEAR || state_q == B_CALC))
  `DSRL_ASSERT(a_min_range, clk_i, rst_ni, (state_q == B_OUT) |-> (min_q <= dsrl_pkg::MIN_TOP))
  `DSRL_ASSERT_ALWAYS(a_reset_clear, clk_i, !rst_ni |=> (state_q == B_CLEAR || rst_ni))

endmodule
`default_nettype wire

/* rtl/decaying_sketch_rate_limiter_unit.sv */
// pacing: set by the hash multiply/mix loop and the table read-modify-write;
// a collision adds a multiply and mix retry, or past MAX_TRIES a fallback scan;
// the front takes a new packet once the last probe of the previous one is queued
// disabled filter: a packet skips the hash chain and leaves the table alone
// reset sets the control and configuration registers, then a clearing pass zeroes
// the table; packets queue up until it is done, configuration writes go through
// ----------------------------------------------------------------------------
// decaying_sketch_rate_limiter_unit
// count-min sketch rate limiter with heat decay and apb configuration
// ----------------------------------------------------------------------------
`default_nettype none
module decaying_sketch_rate_limiter_unit #(
  parameter int unsigned TABLE_DEPTH = dsrl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned PROBE_COUNT = dsrl_pkg::PROBE_COUNT_DEF,
  parameter int unsigned DECAY_SHIFT = dsrl_pkg::DECAY_SHIFT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dsrl_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dsrl_pkg::out_t      out_data_o
);
  logic enable_q;
  logic [31:0] seed_q, thresh_q;
  logic push, full, pop, qvalid;
  dsrl_pkg::probe_t wprobe, rprobe;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      seed_q   <= 32'd1;
      thresh_q <= 32'd65535;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        dsrl_pkg::REG_FILTER_ENABLE:  enable_q <= pwdata[0];
        dsrl_pkg::REG_HASH_SEED:      seed_q   <= pwdata;
        dsrl_pkg::REG_HEAT_THRESHOLD: thresh_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      dsrl_pkg::REG_FILTER_ENABLE:  prdata = {31'd0, enable_q};
      dsrl_pkg::REG_HASH_SEED:      prdata = seed_q;
      dsrl_pkg::REG_HEAT_THRESHOLD: prdata = thresh_q;
      default:                      prdata = 32'd0;
    endcase
  end

  dsrl_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PROBE_COUNT(PROBE_COUNT),
    .DECAY_SHIFT(DECAY_SHIFT)
  ) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .enable_i(enable_q), .seed_i(seed_q),
    .push_o(push), .full_i(full), .probe_o(wprobe)
  );

  dsrl_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(push), .wdata_i(wprobe), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .rdata_o(rprobe)
  );

  dsrl_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(qvalid), .probe_i(rprobe), .pop_o(pop),
    .threshold_i(thresh_q),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

endmodule
`default_nettype wire
